// File: rtl/wsd_pkg.sv
// Package for the WebSocket frame deframer: result type, header constants,
// status codes and the header-length helper. No dependencies.
package wsd_pkg;

    // Default width of the payload length counter
    localparam int DEF_LENGTH_BITS = 64;
    // Width of the payload_length result field
    localparam int PAY_LEN_W       = 64;

    // Header layout
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] HDR_BASE   = 4'd2;
    localparam logic [3:0] EXT16_LEN  = 4'd2;
    localparam logic [3:0] EXT64_LEN  = 4'd8;
    localparam logic [3:0] KEY_LEN    = 4'd4;

    // Frame status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SHORT    = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    // One result beat
    typedef struct packed {
        logic [7:0]           out_byte;
        logic                 has_data;
        logic                 frame_end;
        logic [1:0]           status;
        logic                 fin_bit;
        logic [2:0]           rsv_bits;
        logic [3:0]           opcode_val;
        logic                 masked_flag;
        logic [PAY_LEN_W-1:0] payload_length;
    } t_result;

    // Number of extended length bytes selected by the 7-bit length
    function automatic logic [3:0] ext_len(input logic [7:0] shb);
        logic [3:0] n;
        n = 4'd0;
        if (shb[6:0] == LEN7_EXT16) n = EXT16_LEN;
        if (shb[6:0] == LEN7_EXT64) n = EXT64_LEN;
        return n;
    endfunction

    // Total header bytes needed, given what has been received so far
    function automatic logic [3:0] hdr_need(input logic [3:0] pos, input logic [7:0] shb);
        logic [3:0] n;
        if (pos < HDR_BASE) begin
            n = HDR_BASE;
        end else begin
            n = HDR_BASE + ext_len(shb) + (shb[7] ? KEY_LEN : 4'd0);
        end
        return n;
    endfunction

endpackage

// File: rtl/wsd_if.sv
// Valid/ready channel interfaces for the deframer: raw byte beats in,
// result beats out. Depends on wsd_pkg.
interface wsd_in_if import wsd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_buffer;

    modport source (output valid, output in_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface wsd_out_if import wsd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [7:0]           out_byte;
    logic                 has_data;
    logic                 frame_end;
    logic [1:0]           status;
    logic                 fin_bit;
    logic [2:0]           rsv_bits;
    logic [3:0]           opcode_val;
    logic                 masked_flag;
    logic [PAY_LEN_W-1:0] payload_length;

    modport source (output valid, output out_byte, output has_data, output frame_end,
                    output status, output fin_bit, output rsv_bits, output opcode_val,
                    output masked_flag, output payload_length, input ready);
    modport sink   (input valid, input out_byte, input has_data, input frame_end,
                    input status, input fin_bit, input rsv_bits, input opcode_val,
                    input masked_flag, input payload_length, output ready);
endinterface

// File: rtl/wsd_core.sv
// Frame state and per-beat parse logic: header capture, payload unmask,
// length accounting and end-of-frame status. Depends on wsd_pkg.
module wsd_core import wsd_pkg::*; #(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_unmask_on,
    output logic       o_res_valid,
    output t_result    o_res
);

    // Frame state
    logic [3:0]             r_hp,   n_hp;
    logic [7:0]             r_fhb,  n_fhb;
    logic [7:0]             r_shb,  n_shb;
    logic [63:0]            r_decl, n_decl;
    logic [31:0]            r_key,  n_key;
    logic [LENGTH_BITS-1:0] r_pc,   n_pc;
    logic                   r_ovr,  n_ovr;

    logic                   in_hdr;
    logic                   data;
    logic [7:0]             ob;
    logic [7:0]             key_b;
    logic [LENGTH_BITS-1:0] eff_cur;
    logic [LENGTH_BITS-1:0] eff_nxt;

    // Declared length saturated to the counter width
    function automatic logic [LENGTH_BITS-1:0] eff_len(input logic [63:0] d);
        logic [LENGTH_BITS-1:0] e;
        if ((d >> LENGTH_BITS) != 64'd0) e = '1;
        else                             e = d[LENGTH_BITS-1:0];
        return e;
    endfunction

    assign eff_cur = eff_len(r_decl);
    assign in_hdr  = r_hp < hdr_need(r_hp, r_shb);

    // Key byte for this payload index, byte 0 most significant
    always_comb begin
        case (r_pc[1:0])
            2'd0:    key_b = r_key[31:24];
            2'd1:    key_b = r_key[23:16];
            2'd2:    key_b = r_key[15:8];
            default: key_b = r_key[7:0];
        endcase
    end

    // Next state for this beat
    always_comb begin
        n_hp   = r_hp;
        n_fhb  = r_fhb;
        n_shb  = r_shb;
        n_decl = r_decl;
        n_key  = r_key;
        n_pc   = r_pc;
        n_ovr  = r_ovr;
        data   = 1'b0;
        ob     = 8'd0;
        if (in_hdr) begin
            if (r_hp == 4'd0) begin
                n_fhb = i_byte;
            end else if (r_hp == 4'd1) begin
                n_shb  = i_byte;
                n_decl = (i_byte[6:0] < LEN7_EXT16) ? {57'd0, i_byte[6:0]} : 64'd0;
            end else if (r_hp < HDR_BASE + ext_len(r_shb)) begin
                n_decl = {r_decl[55:0], i_byte};
            end else begin
                n_key = {r_key[23:0], i_byte};
            end
            n_hp = r_hp + 4'd1;
        end else if (r_pc < eff_cur) begin
            data = 1'b1;
            ob   = (r_shb[7] && i_unmask_on) ? (i_byte ^ key_b) : i_byte;
            n_pc = r_pc + LENGTH_BITS'(1);
        end else begin
            n_ovr = 1'b1;
        end
    end

    assign eff_nxt = eff_len(n_decl);

    // Result beat, built from the updated state
    always_comb begin
        o_res          = '0;
        o_res.out_byte = ob;
        o_res.has_data = data;
        if (i_last) begin
            o_res.frame_end = 1'b1;
            if (n_hp < hdr_need(n_hp, n_shb))       o_res.status = STATUS_SHORT;
            else if (n_ovr || (n_pc != eff_nxt))    o_res.status = STATUS_MISMATCH;
            else                                    o_res.status = STATUS_OK;
            o_res.fin_bit        = n_fhb[7];
            o_res.rsv_bits       = n_fhb[6:4];
            o_res.opcode_val     = n_fhb[3:0];
            o_res.masked_flag    = n_shb[7];
            o_res.payload_length = PAY_LEN_W'(eff_nxt);
        end
    end

    assign o_res_valid = i_en && (data || i_last);

    // State registers; the last beat of a buffer clears the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_hp   <= '0;
            r_fhb  <= '0;
            r_shb  <= '0;
            r_decl <= '0;
            r_key  <= '0;
            r_pc   <= '0;
            r_ovr  <= 1'b0;
        end else if (i_en) begin
            r_hp   <= n_hp;
            r_fhb  <= n_fhb;
            r_shb  <= n_shb;
            r_decl <= n_decl;
            r_key  <= n_key;
            r_pc   <= n_pc;
            r_ovr  <= n_ovr;
        end
    end

endmodule

// File: rtl/wsd_out_stage.sv
// Result register driving the output channel; takes a new beat whenever it
// is empty or its beat is being taken. Depends on wsd_pkg and wsd_if.
module wsd_out_stage import wsd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_result   i_res,
    output logic      o_free,
    wsd_out_if.source o_out
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    // Valid flag
    always_comb begin
        n_valid = r_valid;
        if (i_load)           n_valid = 1'b1;
        else if (o_out.ready) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.out_byte       = r_res.out_byte;
    assign o_out.has_data       = r_res.has_data;
    assign o_out.frame_end      = r_res.frame_end;
    assign o_out.status         = r_res.status;
    assign o_out.fin_bit        = r_res.fin_bit;
    assign o_out.rsv_bits       = r_res.rsv_bits;
    assign o_out.opcode_val     = r_res.opcode_val;
    assign o_out.masked_flag    = r_res.masked_flag;
    assign o_out.payload_length = r_res.payload_length;

endmodule

// File: rtl/websocket_frame_deframer_top.sv
// WebSocket frame deframer, top level. A byte beat is registered, parsed
// combinationally against the frame state, and its result (if any) lands in
// the output register. Throughput one byte per cycle unless the output stalls.
// Synchronous active-low reset clears the frame state and turns unmasking on.
// Depends on wsd_pkg, wsd_if, wsd_core, wsd_out_stage.
module websocket_frame_deframer_top import wsd_pkg::*; #(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    wsd_in_if.sink    i_in,
    wsd_out_if.source o_out
);

    logic       r_unmask_on;
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;

    logic       out_free;
    logic       s1_go;
    logic       res_valid;
    t_result    res;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unmask_on <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_unmask_on <= i_cfg_wr_data;
        end
    end

    // Input register
    assign s1_go      = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_byte <= i_in.in_byte;
            r_s1_last <= i_in.end_of_buffer;
        end
    end

    // Parse
    wsd_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (s1_go),
        .i_byte      (r_s1_byte),
        .i_last      (r_s1_last),
        .i_unmask_on (r_unmask_on),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register
    wsd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule

// File: tb/sv/tb_websocket_frame_deframer_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for websocket_frame_deframer_top: a directed table, then
// random frame buffers, checked beat by beat against an in-bench frame parser.
// Depends on wsd_pkg, wsd_if and the deframer RTL.
module tb_websocket_frame_deframer_top;
    import wsd_pkg::*;

    localparam int          LEN_BITS     = DEF_LENGTH_BITS;
    localparam int unsigned STALL_LIMIT  = 4000;  // cycles with no beat on either side
    localparam int unsigned HOLD_CYCLES  = 300;   // long output hold-off
    localparam int unsigned PHASE_BEATS  = 200;   // random input beats per phase
    localparam int unsigned SHOW_LIMIT   = 10;    // mismatches printed in full

    typedef struct {
        logic [7:0] in_byte;
        logic       last;
        logic       typed;    // expected result written out in the row
        t_result    res;
    } t_dir_row;

    typedef struct {
        logic    typed;
        t_result res;
    } t_beat_note;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    wsd_in_if  in_ch();
    wsd_out_if out_ch();

    websocket_frame_deframer_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in         (in_ch),
        .o_out        (out_ch)
    );

    // Parser state, mirrors the block
    logic [3:0]  fr_hdr_pos;
    logic [7:0]  fr_b0;
    logic [7:0]  fr_b1;
    logic [63:0] fr_len;
    logic [31:0] fr_key;
    logic [63:0] fr_count;
    logic        fr_overrun;
    logic        unmask_en;

    t_result    expected_beats[$];
    t_beat_note typed_notes[$];
    t_dir_row   dir_rows[$];
    logic [7:0] frame_q[$];

    logic        tx_idle_en;
    logic        rx_idle_en;
    logic        hold_req;
    int unsigned mismatches;
    int unsigned beats_sent;
    int unsigned buffers_sent;
    int unsigned results_seen;
    int unsigned n_ok;
    int unsigned n_short;
    int unsigned n_size_err;
    int unsigned holds_done;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Frame parser
    // ------------------------------------------------------------------
    function automatic logic [63:0] len_eff();
        logic [63:0] cap;
        cap = (LEN_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LEN_BITS) - 64'd1);
        return (fr_len > cap) ? cap : fr_len;
    endfunction

    function automatic logic [3:0] ext_bytes();
        if (fr_b1[6:0] == LEN7_EXT16) return 4'd2;
        if (fr_b1[6:0] == LEN7_EXT64) return 4'd8;
        return 4'd0;
    endfunction

    function automatic logic [3:0] header_bytes_due();
        if (fr_hdr_pos < 4'd2) return 4'd2;
        return 4'd2 + ext_bytes() + (fr_b1[7] ? 4'd4 : 4'd0);
    endfunction

    function automatic void clear_frame();
        fr_hdr_pos = '0;
        fr_b0      = '0;
        fr_b1      = '0;
        fr_len     = '0;
        fr_key     = '0;
        fr_count   = '0;
        fr_overrun = 1'b0;
    endfunction

    // Consume one byte; returns 1 when the byte produces a result beat
    function automatic logic deframe_byte(input logic [7:0] b, input logic last,
                                          output t_result r);
        logic       data;
        logic [7:0] ob;
        int         sh;
        r    = '0;
        data = 1'b0;
        ob   = 8'h00;
        if (fr_hdr_pos < header_bytes_due()) begin
            if (fr_hdr_pos == 4'd0) begin
                fr_b0 = b;
            end else if (fr_hdr_pos == 4'd1) begin
                fr_b1  = b;
                fr_len = (b[6:0] < LEN7_EXT16) ? {57'd0, b[6:0]} : 64'd0;
            end else if (fr_hdr_pos < 4'd2 + ext_bytes()) begin
                fr_len = {fr_len[55:0], b};
            end else begin
                fr_key = {fr_key[23:0], b};
            end
            fr_hdr_pos = fr_hdr_pos + 4'd1;
        end else if (fr_count < len_eff()) begin
            ob = b;
            if (fr_b1[7] && unmask_en) begin
                sh = 8 * (3 - int'(fr_count[1:0]));
                ob = ob ^ fr_key[sh +: 8];
            end
            fr_count = fr_count + 64'd1;
            data     = 1'b1;
        end else begin
            fr_overrun = 1'b1;
        end

        if (!data && !last) return 1'b0;

        r.out_byte = ob;
        r.has_data = data;
        if (last) begin
            r.frame_end = 1'b1;
            if (fr_hdr_pos < header_bytes_due())
                r.status = STATUS_SHORT;
            else if (fr_overrun || fr_count != len_eff())
                r.status = STATUS_MISMATCH;
            else
                r.status = STATUS_OK;
            r.fin_bit        = fr_b0[7];
            r.rsv_bits       = fr_b0[6:4];
            r.opcode_val     = fr_b0[3:0];
            r.masked_flag    = fr_b1[7];
            r.payload_length = len_eff();
            clear_frame();
        end
        return 1'b1;
    endfunction

    // Hand-written end-of-buffer beat, header fields taken from byte 0
    function automatic t_result end_beat(input logic [7:0] ob, input logic hd,
                                         input logic [1:0] st, input logic [7:0] b0,
                                         input logic mk, input logic [63:0] len);
        t_result r;
        r                = '0;
        r.out_byte       = ob;
        r.has_data       = hd;
        r.frame_end      = 1'b1;
        r.status         = st;
        r.fin_bit        = b0[7];
        r.rsv_bits       = b0[6:4];
        r.opcode_val     = b0[3:0];
        r.masked_flag    = mk;
        r.payload_length = len;
        return r;
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf("byte=%h data=%b end=%b st=%0d fin=%b rsv=%0d op=%h mask=%b len=%h",
                         r.out_byte, r.has_data, r.frame_end, r.status, r.fin_bit,
                         r.rsv_bits, r.opcode_val, r.masked_flag, r.payload_length);
    endfunction

    // ------------------------------------------------------------------
    // Monitors: result check, config tracking, prediction on input beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result    seen;
        t_result    want;
        t_result    predicted;
        t_beat_note note;
        if (i_rst_n === 1'b1) begin
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                seen                = '0;
                seen.out_byte       = out_ch.out_byte;
                seen.has_data       = out_ch.has_data;
                seen.frame_end      = out_ch.frame_end;
                seen.status         = out_ch.status;
                seen.fin_bit        = out_ch.fin_bit;
                seen.rsv_bits       = out_ch.rsv_bits;
                seen.opcode_val     = out_ch.opcode_val;
                seen.masked_flag    = out_ch.masked_flag;
                seen.payload_length = out_ch.payload_length;
                results_seen++;
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("[%0t] unexpected result beat: %s",
                                 $realtime, fmt_result(seen));
                end else begin
                    want = expected_beats.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT) begin
                            $display("[%0t] result %0d differs", $realtime, results_seen);
                            $display("    expected %s", fmt_result(want));
                            $display("    actual   %s", fmt_result(seen));
                        end
                    end
                    if (want.frame_end) begin
                        if (want.status == STATUS_OK)         n_ok++;
                        else if (want.status == STATUS_SHORT) n_short++;
                        else                                  n_size_err++;
                    end
                end
            end

            if (i_cfg_wr_en === 1'b1)
                unmask_en = i_cfg_wr_data;

            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                note = typed_notes.pop_front();
                if (deframe_byte(in_ch.in_byte, in_ch.end_of_buffer, predicted))
                    expected_beats.push_back(note.typed ? note.res : predicted);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int unsigned wait_n;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                wait_n   = HOLD_CYCLES;
                hold_req = 1'b0;
                holds_done++;
            end else begin
                wait_n = rx_idle_en ? $urandom_range(0, 9) : 0;
            end
            if (wait_n != 0) begin
                out_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
        end
    end

    // Watchdog: ends the run when no beat moves for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no beat for %0d cycles, %0d results outstanding",
                 $realtime, quiet, expected_beats.size());
        $display("websocket_frame_deframer_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] b, input logic last,
                             input logic typed, input t_result res);
        int unsigned gap;
        t_beat_note  note;
        gap        = tx_idle_en ? $urandom_range(0, 9) : 0;
        note.typed = typed;
        note.res   = res;
        typed_notes.push_back(note);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= b;
        in_ch.end_of_buffer <= last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        beats_sent++;
    endtask

    task automatic send_buffer();
        int i;
        for (i = 0; i < frame_q.size(); i++)
            send_beat(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
        buffers_sent++;
    endtask

    // Stop offering, wait for every expected result, then let the pipe settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_unmask(input logic v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic add_row(input logic [7:0] b, input logic last,
                           input logic typed, input t_result res);
        t_dir_row row;
        row.in_byte = b;
        row.last    = last;
        row.typed   = typed;
        row.res     = res;
        dir_rows.push_back(row);
    endtask

    // Random buffer: mostly well-formed frames, some cut short, overlong or noise
    task automatic build_random_frame();
        int unsigned kind;
        int unsigned plen;
        int unsigned enc;
        int unsigned hdr_n;
        int unsigned cut;
        int          i;
        logic        masked;
        logic [63:0] lenf;
        frame_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom));
        end else begin
            plen   = ($urandom_range(0, 19) == 0) ? $urandom_range(126, 300)
                                                  : $urandom_range(0, 40);
            masked = 1'($urandom);
            lenf   = 64'(plen);
            frame_q.push_back(8'($urandom));
            enc = (plen >= 126) ? $urandom_range(1, 2) : $urandom_range(0, 3);
            if (enc == 1) begin
                frame_q.push_back({masked, LEN7_EXT16});
                frame_q.push_back(lenf[15:8]);
                frame_q.push_back(lenf[7:0]);
            end else if (enc == 2) begin
                // now and then a huge declared length that the payload never meets
                if ($urandom_range(0, 9) == 0) begin
                    lenf[63:32] = $urandom;
                    lenf[31:16] = 16'($urandom);
                end
                frame_q.push_back({masked, LEN7_EXT64});
                for (i = 7; i >= 0; i--) frame_q.push_back(lenf[8*i +: 8]);
            end else begin
                frame_q.push_back({masked, lenf[6:0]});
            end
            if (masked) repeat (4) frame_q.push_back(8'($urandom));
            hdr_n = frame_q.size();
            repeat (plen) frame_q.push_back(8'($urandom));

            if (kind >= 78 && kind < 86) begin
                // header cut short
                cut = $urandom_range(1, hdr_n - 1);
                while (frame_q.size() > cut) void'(frame_q.pop_back());
            end else if (kind >= 86 && kind < 93 && plen > 0) begin
                // payload cut short
                repeat ($urandom_range(1, plen)) void'(frame_q.pop_back());
            end else if (kind >= 86) begin
                // bytes past the declared length
                repeat ($urandom_range(1, 5)) frame_q.push_back(8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int          i;
        int          phase;
        int unsigned start_beats;
        i_rst_n             <= 1'b0;
        i_cfg_wr_en         <= 1'b0;
        i_cfg_wr_data       <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.in_byte       <= 8'h00;
        in_ch.end_of_buffer <= 1'b0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        hold_req     = 1'b0;
        mismatches   = 0;
        beats_sent   = 0;
        buffers_sent = 0;
        results_seen = 0;
        n_ok         = 0;
        n_short      = 0;
        n_size_err   = 0;
        holds_done   = 0;
        clear_frame();
        unmask_en = 1'b1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, run with unmasking at its reset value
        // lone byte: header ends after byte 0
        add_row(8'hFF, 1'b1, 1'b1, end_beat(8'h00, 1'b0, STATUS_SHORT, 8'hFF, 1'b0, 64'd0));
        // one payload byte declared, two sent: the second is dropped
        add_row(8'h89, 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, '0);
        add_row(8'hAB, 1'b0, 1'b0, '0);
        add_row(8'hCD, 1'b1, 1'b1, end_beat(8'h00, 1'b0, STATUS_MISMATCH, 8'h89, 1'b0, 64'd1));
        // masked, 16-bit length of 2, key 01 02 03 04
        add_row(8'h82, 1'b0, 1'b0, '0);
        add_row(8'hFE, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h02, 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, '0);
        add_row(8'h02, 1'b0, 1'b0, '0);
        add_row(8'h03, 1'b0, 1'b0, '0);
        add_row(8'h04, 1'b0, 1'b0, '0);
        add_row(8'hF0, 1'b0, 1'b0, '0);
        add_row(8'h0F, 1'b1, 1'b1, end_beat(8'h0D, 1'b1, STATUS_OK, 8'h82, 1'b1, 64'd2));
        // 64-bit length of all ones, no payload at all
        add_row(8'h70, 1'b0, 1'b0, '0);
        add_row(8'h7F, 1'b0, 1'b0, '0);
        for (i = 0; i < 7; i++) add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b1,
                end_beat(8'h00, 1'b0, STATUS_MISMATCH, 8'h70, 1'b0, {64{1'b1}}));

        foreach (dir_rows[k])
            send_beat(dir_rows[k].in_byte, dir_rows[k].last,
                      dir_rows[k].typed, dir_rows[k].res);
        buffers_sent += 4;
        drain();

        // Random phases: idling on both, neither, input only, output only
        for (phase = 0; phase < 4; phase++) begin
            tx_idle_en = (phase % 2 == 0);
            rx_idle_en = (phase == 0) || (phase == 3);
            set_unmask(phase % 2 == 1);
            start_beats = beats_sent;
            while (beats_sent - start_beats < PHASE_BEATS) begin
                build_random_frame();
                send_buffer();
            end
            drain();
        end

        // Back-pressure: output held off while a long frame streams in
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_req   = 1'b1;
        frame_q.delete();
        frame_q.push_back(8'h82);
        frame_q.push_back({1'b0, LEN7_EXT16});
        frame_q.push_back(8'h00);
        frame_q.push_back(8'd150);
        repeat (150) frame_q.push_back(8'($urandom));
        send_buffer();
        drain();

        if (expected_beats.size() != 0) begin
            $display("%0d expected results never arrived", expected_beats.size());
            mismatches += expected_beats.size();
        end

        $display("Sent %0d byte beats in %0d buffers; %0d result beats checked.",
                 beats_sent, buffers_sent, results_seen);
        $display("Frames: %0d ok, %0d short header, %0d size error; %s %0d hold-off.",
                 n_ok, n_short, n_size_err, "unmask on/off;", holds_done);
        if (mismatches == 0)
            $display("websocket_frame_deframer_top: match");
        else
            $display("websocket_frame_deframer_top: mismatch");
        $finish;
    end

endmodule
